// File: rtl/ddo_pkg.sv
// Shared types, constants and the arctangent table for the odometry block.
`default_nettype none
package ddo_pkg;

  localparam int unsigned DivW = 68;
  localparam int unsigned DvsW = 21;
  localparam logic signed [33:0] CordicK = 34'sd652032875;
  localparam logic signed [33:0] QuarterTurn = 34'sd1073741824;
  localparam logic [19:0] MicrosPerS = 20'd1000000;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic [29:0] atan_bam(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0: v = 30'd536870912;
      5'd1: v = 30'd316933406;
      5'd2: v = 30'd167458907;
      5'd3: v = 30'd85004756;
      5'd4: v = 30'd42667331;
      5'd5: v = 30'd21354465;
      5'd6: v = 30'd10679838;
      5'd7: v = 30'd5340245;
      5'd8: v = 30'd2670163;
      5'd9: v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ddo_mul.sv
// Shared signed multiplier with registered product.
`default_nettype none
module ddo_mul (
  input  wire logic                clk_i,
  input  wire logic signed [32:0]  a_i,
  input  wire logic signed [32:0]  b_i,
  output logic signed [65:0]       p_o
);

  logic signed [65:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

// File: rtl/ddo_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module ddo_div (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [ddo_pkg::DivW-1:0]     dividend_i,
  input  wire logic [ddo_pkg::DvsW-1:0]     divisor_i,
  output ddo_pkg::unit_stat_t               stat_o,
  output logic [ddo_pkg::DivW-1:0]          quot_o
);

  logic [ddo_pkg::DivW-1:0] quot_q;
  logic [ddo_pkg::DvsW-1:0] rem_q, dvs_q;
  logic [6:0]               cnt_q;
  logic                     busy_q, done_q;
  logic [ddo_pkg::DvsW:0]   trial;
  logic                     fits;

  assign trial = {rem_q, quot_q[ddo_pkg::DivW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'(ddo_pkg::DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? (trial[ddo_pkg::DvsW-1:0] - dvs_q) : trial[ddo_pkg::DvsW-1:0];
      quot_q <= {quot_q[ddo_pkg::DivW-2:0], fits};
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quot_o = quot_q;

endmodule
`default_nettype wire

// File: rtl/ddo_cordic.sv
// Iterative CORDIC rotation giving cos and sin of a binary angle in Q30.
`default_nettype none
module ddo_cordic #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [31:0]        angle_i,
  output ddo_pkg::unit_stat_t     stat_o,
  output logic signed [33:0]      cos_o,
  output logic signed [33:0]      sin_o
);

  localparam int unsigned CntW = $clog2(CORDIC_STEPS);

  logic signed [33:0] x_q, y_q, z_q, dx, dy, at;
  logic signed [33:0] za, zf;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, done_q, flip_q;
  logic [31:0]        rot;

  assign za  = {{2{angle_i[31]}}, angle_i};
  assign rot = angle_i + 32'h8000_0000;
  assign zf  = {{2{rot[31]}}, rot};
  assign dx  = y_q >>> cnt_q;
  assign dy  = x_q >>> cnt_q;
  assign at  = {4'b0, ddo_pkg::atan_bam(5'(cnt_q))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= ddo_pkg::CordicK;
      y_q <= '0;
      if (za > ddo_pkg::QuarterTurn || za < -ddo_pkg::QuarterTurn) begin
        z_q    <= zf;
        flip_q <= 1'b1;
      end else begin
        z_q    <= za;
        flip_q <= 1'b0;
      end
    end else if (busy_q) begin
      if (!z_q[33]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule
`default_nettype wire

// File: rtl/differential_drive_odometry_top.sv
// Differential-drive odometry: sequencer, pose state and output register.
//
// Input channel: in_valid_i / in_stall_o carries one sample (left_count_i,
// right_count_i, period_us_i). Output channel: out_valid_o / out_stall_i
// carries speed, turn rate, heading and position. An item moves on a rising
// edge with valid high and stall low. Configuration writes use cfg_we_i,
// cfg_idx_i (0 left scale, 1 right scale, 2 heading gain) and cfg_data_i.
// From one input acceptance to the next, each sample runs two passes of the
// bit-serial divider (68 steps each) for speed and turn rate, a CORDIC
// rotation of CORDIC_STEPS steps, and the sequencer steps that make eleven
// uses of the shared multiplier.
// One sample is in work at a time; in_stall_o is high while it is.
// The finished result sits in an output register, so the next sample is
// taken while that result waits. If the receiver stalls and a second result
// is ready, the sequencer holds until the register frees.
// Reset clears the pose, the previous counts and the output valid, and sets
// the scales to 65536 and the gain to 17180.
`default_nettype none
module differential_drive_odometry_top #(
  parameter int unsigned CORDIC_STEPS = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [31:0] left_count_i,
  input  wire logic signed [31:0] right_count_i,
  input  wire logic [19:0]        period_us_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      speed_o,
  output logic signed [47:0]      turn_rate_o,
  output logic signed [31:0]      heading_o,
  output logic signed [47:0]      pos_x_o,
  output logic signed [47:0]      pos_y_o
);

  typedef enum logic [23:0] {
    S_IDLE = 24'h000001, S_ML  = 24'h000002, S_MR  = 24'h000004,
    S_HLO  = 24'h000008, S_HHI = 24'h000010, S_RND = 24'h000020,
    S_SUM  = 24'h000040, S_SPL = 24'h000080, S_SPH = 24'h000100,
    S_SPD  = 24'h000200, S_SPW = 24'h000400, S_TRM = 24'h000800,
    S_TRD  = 24'h001000, S_TRW = 24'h002000, S_COR = 24'h004000,
    S_CORW = 24'h008000, S_XL  = 24'h010000, S_XH  = 24'h020000,
    S_XA   = 24'h040000, S_YL  = 24'h080000, S_YH  = 24'h100000,
    S_YA   = 24'h200000, S_OUT = 24'h400000, S_SPARE = 24'h800000
  } state_e;

  localparam logic [1:0] RegLeftScale  = 2'd0;
  localparam logic [1:0] RegRightScale = 2'd1;
  localparam logic [1:0] RegGain       = 2'd2;

  state_e state_q, state_d;

  logic [31:0] left_scale_q, right_scale_q, gain_q;
  logic [31:0] prev_left_q, prev_right_q, heading_q;
  logic signed [47:0] x_q, y_q;
  logic [31:0] step_l_q, step_r_q;
  logic [19:0] period_q;
  logic [63:0] dlq_q, drq_q, diff_q, hlo_q, acc_q;
  logic signed [47:0] dl_q, dr_q;
  logic signed [48:0] sum_q;
  logic [31:0] hstep_q;
  logic signed [31:0] speed_q;
  logic signed [47:0] turn_q;

  logic out_valid_q;
  logic signed [31:0] speed_oq, heading_oq;
  logic signed [47:0] turn_oq, x_oq, y_oq;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;
  logic               div_start, cor_start;
  logic [ddo_pkg::DivW-1:0] div_dividend, quot;
  logic [ddo_pkg::DvsW-1:0] div_divisor;
  ddo_pkg::unit_stat_t div_stat, cor_stat;
  logic signed [33:0] cos_v, sin_v;

  logic        in_acc;
  logic [47:0] sum_mag;
  logic signed [47:0] mean;
  logic [47:0] amag;
  logic [31:0] cmag, smag, hmag;
  logic [79:0] pos_full;
  logic [49:0] pos_step;
  logic        neg_x, neg_y;
  logic [31:0] dh;

  function automatic logic signed [47:0] q16_round(input logic [63:0] q);
    logic [63:0] mag;
    logic [47:0] r;
    mag = q[63] ? -q : q;
    r = 48'((mag + 64'h8000) >> 16);
    return q[63] ? -r : r;
  endfunction

  function automatic logic signed [47:0] acc_sat(input logic signed [47:0] acc,
                                                 input logic [49:0] st,
                                                 input logic neg);
    logic signed [51:0] s;
    s = {{4{acc[47]}}, acc} + (neg ? -{2'b0, st} : {2'b0, st});
    if (s > 52'sh0_7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
    if (s < -52'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
    return s[47:0];
  endfunction

  ddo_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  ddo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (quot)
  );

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (heading_q),
    .stat_o  (cor_stat),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign sum_mag = sum_q[48] ? 48'(-sum_q) : 48'(sum_q);
  assign mean    = 48'((sum_q + {48'b0, sum_q[48]}) >>> 1);
  assign amag    = mean[47] ? -mean : mean;
  assign cmag    = cos_v[33] ? 32'(-cos_v) : 32'(cos_v);
  assign smag    = sin_v[33] ? 32'(-sin_v) : 32'(sin_v);
  assign hmag    = hstep_q[31] ? -hstep_q : hstep_q;
  assign neg_x   = mean[47] ^ cos_v[33];
  assign neg_y   = mean[47] ^ sin_v[33];
  assign pos_full = {prod[55:0], 24'b0} + {16'b0, acc_q};
  assign pos_step = pos_full[79:30];
  assign dh       = hlo_q[63:32] + prod[31:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ML: begin
        mul_a = {step_l_q[31], step_l_q};
        mul_b = {1'b0, left_scale_q};
      end
      S_MR: begin
        mul_a = {step_r_q[31], step_r_q};
        mul_b = {1'b0, right_scale_q};
      end
      S_HHI: begin
        mul_a = {1'b0, diff_q[31:0]};
        mul_b = {1'b0, gain_q};
      end
      S_RND: begin
        mul_a = {1'b0, diff_q[63:32]};
        mul_b = {1'b0, gain_q};
      end
      S_SPL: begin
        mul_a = {9'b0, sum_mag[23:0]};
        mul_b = {13'b0, ddo_pkg::MicrosPerS};
      end
      S_SPH: begin
        mul_a = {9'b0, sum_mag[47:24]};
        mul_b = {13'b0, ddo_pkg::MicrosPerS};
      end
      S_TRM: begin
        mul_a = {1'b0, hmag};
        mul_b = {13'b0, ddo_pkg::MicrosPerS};
      end
      S_XL: begin
        mul_a = {9'b0, amag[23:0]};
        mul_b = {1'b0, cmag};
      end
      S_XH: begin
        mul_a = {9'b0, amag[47:24]};
        mul_b = {1'b0, cmag};
      end
      S_YL: begin
        mul_a = {9'b0, amag[23:0]};
        mul_b = {1'b0, smag};
      end
      S_YH: begin
        mul_a = {9'b0, amag[47:24]};
        mul_b = {1'b0, smag};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    if (state_q == S_SPD) begin
      div_start    = 1'b1;
      div_dividend = {prod[43:0], 24'b0} + {4'b0, acc_q};
      div_divisor  = {period_q, 1'b0};
    end else if (state_q == S_TRD) begin
      div_start    = 1'b1;
      div_dividend = {16'b0, prod[51:0]};
      div_divisor  = {1'b0, period_q};
    end
  end

  assign cor_start = (state_q == S_COR);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_acc) state_d = S_ML;
      S_ML:   state_d = S_MR;
      S_MR:   state_d = S_HLO;
      S_HLO:  state_d = S_HHI;
      S_HHI:  state_d = S_RND;
      S_RND:  state_d = S_SUM;
      S_SUM:  state_d = S_SPL;
      S_SPL:  state_d = S_SPH;
      S_SPH:  state_d = S_SPD;
      S_SPD:  state_d = S_SPW;
      S_SPW:  if (div_stat.done) state_d = S_TRM;
      S_TRM:  state_d = S_TRD;
      S_TRD:  state_d = S_TRW;
      S_TRW:  if (div_stat.done) state_d = S_COR;
      S_COR:  state_d = S_CORW;
      S_CORW: if (cor_stat.done) state_d = S_XL;
      S_XL:   state_d = S_XH;
      S_XH:   state_d = S_XA;
      S_XA:   state_d = S_YL;
      S_YL:   state_d = S_YH;
      S_YH:   state_d = S_YA;
      S_YA:   state_d = S_OUT;
      S_OUT:  if (!(out_valid_q && out_stall_i)) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      left_scale_q  <= 32'd65536;
      right_scale_q <= 32'd65536;
      gain_q        <= 32'd17180;
      prev_left_q   <= '0;
      prev_right_q  <= '0;
      heading_q     <= '0;
      x_q           <= '0;
      y_q           <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegLeftScale:  left_scale_q  <= cfg_data_i;
          RegRightScale: right_scale_q <= cfg_data_i;
          RegGain:       gain_q        <= cfg_data_i;
          default:       ;
        endcase
      end
      if (in_acc) begin
        prev_left_q  <= left_count_i;
        prev_right_q <= right_count_i;
      end
      if (state_q == S_SUM) heading_q <= heading_q + dh;
      if (state_q == S_XA) x_q <= acc_sat(x_q, pos_step, neg_x);
      if (state_q == S_YA) y_q <= acc_sat(y_q, pos_step, neg_y);
      if (state_q == S_OUT && !(out_valid_q && out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      step_l_q <= left_count_i - prev_left_q;
      step_r_q <= right_count_i - prev_right_q;
      period_q <= (period_us_i == '0) ? 20'd1 : period_us_i;
    end
    case (state_q)
      S_MR:  dlq_q <= prod[63:0];
      S_HLO: begin
        drq_q  <= prod[63:0];
        diff_q <= prod[63:0] - dlq_q;
      end
      S_RND: begin
        hlo_q <= prod[63:0];
        dl_q  <= q16_round(dlq_q);
        dr_q  <= q16_round(drq_q);
      end
      S_SUM: begin
        hstep_q <= dh;
        sum_q   <= {dl_q[47], dl_q} + {dr_q[47], dr_q};
      end
      S_SPH, S_XH, S_YH: acc_q <= prod[63:0];
      S_SPW: if (div_stat.done) begin
        if (|quot[67:31]) speed_q <= sum_q[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else speed_q <= sum_q[48] ? -quot[31:0] : quot[31:0];
      end
      S_TRW: if (div_stat.done) begin
        if (|quot[67:47]) turn_q <= hstep_q[31] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        else turn_q <= hstep_q[31] ? -quot[47:0] : quot[47:0];
      end
      S_OUT: if (!(out_valid_q && out_stall_i)) begin
        speed_oq   <= speed_q;
        turn_oq    <= turn_q;
        heading_oq <= heading_q;
        x_oq       <= x_q;
        y_oq       <= y_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign speed_o     = speed_oq;
  assign turn_rate_o = turn_oq;
  assign heading_o   = heading_oq;
  assign pos_x_o     = x_oq;
  assign pos_y_o     = y_oq;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("input taken but block not busy");

  a_div_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == S_SPW || state_q == S_TRW))
    else $error("divider running outside its wait states");

  a_heading_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_SUM |=> $stable(heading_q))
    else $error("heading changed outside its update step");

  a_out_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && state_q != S_OUT |=> !out_valid_o)
    else $error("taken result not cleared");

endmodule
`default_nettype wire
